FILE: hdl/iss_pkg.sv
// Package for the indexed sequence store: operation, status and sequencer codes.
package iss_pkg;

  typedef enum logic [2:0] {
    ACT_ADD_FRONT = 3'd0,
    ACT_ADD_REAR  = 3'd1,
    ACT_REM_FRONT = 3'd2,
    ACT_REM_REAR  = 3'd3,
    ACT_REM_AT    = 3'd4,
    ACT_INS_AT    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_PUT,
    S_TAKE,
    S_GRAB,
    S_REM_RD,
    S_REM_WR,
    S_DONE
  } state_t;

  localparam int ACTION_W   = 3;
  localparam int POSITION_W = 6;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 5;

endpackage

FILE: hdl/iss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/indexed_sequence_store.sv
// Top level of the indexed sequence store: bounded ordered sequence with positional edits.
//
// Holds up to CAPACITY values in order, in a RAM with registered read. Each
// input transfer asks for one operation (add front/rear, remove front/rear,
// remove at a 1-based position, insert before a 1-based position) and yields
// exactly one output transfer with status, removed value (zero unless a
// removal succeeded) and the count after the operation. Elements behind the
// edited position are moved one RAM entry at a time by a small sequencer
// with one pointer: a read state and a write state per moved element. An
// insert walks the pointer down from the end to the edit index, then writes
// the new value; a removal first reads the taken value, then walks up to
// the end. A rejected or ignored request goes straight to the result state.
// in_stall is high while an operation is in flight. The result sits
// in an output register, so the next input transfer can be taken while the
// previous result still waits on out_stall. Failed operations leave the
// store unchanged. Values are kept in their low VALUE_WIDTH bits.
module indexed_sequence_store #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [iss_pkg::ACTION_W-1:0]        action,
  input  logic [iss_pkg::POSITION_W-1:0]      position,
  input  logic [iss_pkg::VALUE_W-1:0]         value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [iss_pkg::STATUS_W-1:0]        status,
  output logic [iss_pkg::VALUE_W-1:0]         removed_value,
  output logic [iss_pkg::OCC_W-1:0]           occupancy
);

  import iss_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // compare width for position against count
  localparam int XW = (CW + 1 > POSITION_W) ? CW + 1 : POSITION_W;

  state_t state, state_next;

  logic [CW-1:0]          count;
  logic [AW-1:0]          ptr;
  logic [AW-1:0]          op_k;
  logic [VALUE_WIDTH-1:0] op_val;
  status_t                res_status;
  logic [VALUE_WIDTH-1:0] rem_val;

  // RAM port signals
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // request decode
  status_t       dec_status;
  logic          dec_nop;
  logic          dec_ins;
  logic [AW-1:0] dec_k;
  logic          full;
  logic          empty;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;

  logic accept;
  logic out_free;
  logic rem_last;

  iss_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign pos_x    = XW'(position);
  assign cnt_x    = XW'(count);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  // last element of the tail reached during a removal
  assign rem_last = ((CW'(ptr) + CW'(1)) == count);

  always_comb begin
    dec_status = ST_OK;
    dec_nop    = 1'b0;
    dec_ins    = 1'b0;
    dec_k      = '0;
    unique case (action)
      ACT_ADD_FRONT: begin
        dec_ins = 1'b1;
        if (full) dec_status = ST_FULL;
      end
      ACT_ADD_REAR: begin
        dec_ins = 1'b1;
        dec_k   = AW'(count);
        if (full) dec_status = ST_FULL;
      end
      ACT_REM_FRONT: begin
        if (empty) dec_status = ST_UNDER;
      end
      ACT_REM_REAR: begin
        dec_k = AW'(count - CW'(1));
        if (empty) dec_status = ST_UNDER;
      end
      ACT_REM_AT: begin
        dec_k = AW'(pos_x - XW'(1));
        if (pos_x == '0 || pos_x > cnt_x) dec_status = ST_RANGE;
      end
      ACT_INS_AT: begin
        dec_ins = 1'b1;
        dec_k   = AW'(pos_x - XW'(1));
        // position is checked before fullness
        if (pos_x == '0 || pos_x > cnt_x + XW'(1)) dec_status = ST_RANGE;
        else if (full) dec_status = ST_FULL;
      end
      default: dec_nop = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (dec_nop || dec_status != ST_OK) state_next = S_DONE;
          else if (dec_ins)                   state_next = S_INS_RD;
          else                                state_next = S_TAKE;
        end
      end
      S_INS_RD: state_next = (ptr == op_k) ? S_PUT : S_INS_WR;
      S_INS_WR: state_next = S_INS_RD;
      S_PUT:    state_next = S_DONE;
      S_TAKE:   state_next = S_GRAB;
      S_GRAB:   state_next = S_REM_RD;
      S_REM_RD: state_next = rem_last ? S_DONE : S_REM_WR;
      S_REM_WR: state_next = S_REM_RD;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: RAM controls and input stall
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = ram_rdata;
    ram_raddr = ptr;
    unique case (state)
      S_IDLE:   in_stall = 1'b0;
      S_INS_RD: ram_raddr = ptr - AW'(1);
      S_INS_WR: ram_we = 1'b1;
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = op_k;
        ram_wdata = op_val;
      end
      S_TAKE:   ram_raddr = op_k;
      S_GRAB:   ram_raddr = op_k;
      S_REM_RD: ram_raddr = ptr + AW'(1);
      S_REM_WR: ram_we = 1'b1;
      S_DONE:   ram_raddr = ptr;
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_PUT:    count <= count + CW'(1);
        S_REM_RD: if (rem_last) count <= count - CW'(1);
        default:  ;
      endcase
      // load a new result, else drop the one just taken
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_k       <= dec_k;
      op_val     <= VALUE_WIDTH'(value);
      ptr        <= AW'(count);
      res_status <= dec_nop ? ST_OK : dec_status;
      rem_val    <= '0;
    end
    case (state)
      S_INS_WR: ptr <= ptr - AW'(1);
      S_GRAB: begin
        rem_val <= ram_rdata;
        ptr     <= op_k;
      end
      S_REM_WR: ptr <= ptr + AW'(1);
      default: ;
    endcase
    if (state == S_DONE && out_free) begin
      status        <= res_status;
      removed_value <= VALUE_W'(rem_val);
      occupancy     <= OCC_W'(count);
    end
  end

endmodule

FILE: tb/tb_indexed_sequence_store.sv
// Self-checking testbench for the indexed sequence store: directed edge cases, then random traffic.
module tb_indexed_sequence_store;
  import iss_pkg::*;

  // The store holds at most this many values (matches the block's default).
  localparam int CAPACITY    = 16;
  localparam int CYCLE_LIMIT = 400000;
  // Drain time after the last result: worst edit walks the whole store.
  localparam int TAIL_CYCLES = 2 * CAPACITY + 20;

  // Action codes 6 and 7 are not operations; the block answers them with ok.
  localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

  typedef struct packed {
    status_t             st;
    logic [VALUE_W-1:0]  taken;
    logic [OCC_W-1:0]    count;
  } seq_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ACTION_W-1:0]   action = '0;
  logic [POSITION_W-1:0] position = '0;
  logic [VALUE_W-1:0]    value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [VALUE_W-1:0]    removed_value;
  logic [OCC_W-1:0]      occupancy;

  // Shadow copy of the sequence, kept in step with every accepted transfer.
  logic [VALUE_W-1:0]    seq_cells [CAPACITY];
  int                    seq_len = 0;
  seq_result_t           pending_results [$];

  int errors      = 0;
  int cycle_count = 0;
  // When set, neither side inserts gaps: back-to-back transfers.
  bit calm = 1'b0;

  indexed_sequence_store #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .position      (position),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_value (removed_value),
    .occupancy     (occupancy)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Insert v at 0-based index k; caller guarantees room.
  function automatic void seq_put(input int k, input logic [VALUE_W-1:0] v);
    for (int i = seq_len; i > k; i--) seq_cells[i] = seq_cells[i-1];
    seq_cells[k] = v;
    seq_len++;
  endfunction

  // Remove and return the value at 0-based index k; caller guarantees k < seq_len.
  function automatic logic [VALUE_W-1:0] seq_take(input int k);
    logic [VALUE_W-1:0] v;
    v = seq_cells[k];
    for (int i = k; i + 1 < seq_len; i++) seq_cells[i] = seq_cells[i+1];
    seq_len--;
    return v;
  endfunction

  // Applies one operation to the shadow sequence and returns the expected response.
  function automatic seq_result_t apply_edit(input logic [ACTION_W-1:0] act,
                                             input logic [POSITION_W-1:0] pos,
                                             input logic [VALUE_W-1:0] val);
    seq_result_t r;
    bit          full;
    int          p;
    full    = (seq_len >= CAPACITY);
    p       = pos;
    r.st    = ST_OK;
    r.taken = '0;
    case (act)
      ACT_ADD_FRONT: begin
        if (full) r.st = ST_FULL;
        else seq_put(0, val);
      end
      ACT_ADD_REAR: begin
        if (full) r.st = ST_FULL;
        else seq_put(seq_len, val);
      end
      ACT_REM_FRONT: begin
        if (seq_len == 0) r.st = ST_UNDER;
        else r.taken = seq_take(0);
      end
      ACT_REM_REAR: begin
        if (seq_len == 0) r.st = ST_UNDER;
        else r.taken = seq_take(seq_len - 1);
      end
      ACT_REM_AT: begin
        if (p < 1 || p > seq_len) r.st = ST_RANGE;
        else r.taken = seq_take(p - 1);
      end
      ACT_INS_AT: begin
        // position is checked before fullness
        if (p < 1 || p > seq_len + 1) r.st = ST_RANGE;
        else if (full) r.st = ST_FULL;
        else seq_put(p - 1, val);
      end
      default: ; // spare codes: nothing changes
    endcase
    r.count = seq_len[OCC_W-1:0];
    return r;
  endfunction

  // Drives one request and returns at the edge of its transfer. The expected
  // response is queued at that same edge; the response itself is registered,
  // so it can never show up in that step.
  task automatic send_op(input logic [ACTION_W-1:0] act,
                         input logic [POSITION_W-1:0] pos,
                         input logic [VALUE_W-1:0] val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    position <= pos;
    value    <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(apply_edit(act, pos, val));
  endtask

  // Response side: random stall before each result, then compare with the oldest expectation.
  initial begin : result_monitor
    int          hold;
    seq_result_t want;
    wait (rst === 1'b0);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $error("response transfer with no request outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          errors++;
        end
        if (removed_value !== want.taken) begin
          $error("removed_value: expected %h, got %h", want.taken, removed_value);
          errors++;
        end
        if (occupancy !== want.count) begin
          $error("occupancy: expected %0d, got %0d", want.count, occupancy);
          errors++;
        end
      end
    end
  end

  // Requests on an empty store that must be refused, plus spare code 7.
  task automatic test_empty_store();
    send_op(ACT_REM_FRONT, 6'd0, 32'hFFFF_FFFF);
    send_op(ACT_REM_REAR, 6'd63, 32'h0);
    send_op(ACT_REM_AT, 6'd0, 32'h0);
    send_op(ACT_REM_AT, 6'd1, 32'h0);
    send_op(ACT_INS_AT, 6'd2, 32'h1234_5678);
    send_op(ACT_SPARE_7, 6'd63, 32'hFFFF_FFFF);
  endtask

  // Fill to capacity from all three add paths, then probe full/range ordering, removal bounds and a spare code.
  task automatic test_fill_to_capacity();
    send_op(ACT_INS_AT, 6'd1, 32'hFFFF_FFFF);
    send_op(ACT_ADD_FRONT, 6'd0, 32'h0000_0000);
    send_op(ACT_ADD_REAR, 6'd63, 32'h8000_0001);
    send_op(ACT_INS_AT, 6'd4, 32'h5A5A_A5A5);   // insert just past the end
    while (seq_len < CAPACITY) send_op(ACT_ADD_REAR, 6'd0, $urandom);
    send_op(ACT_ADD_FRONT, 6'd0, 32'hDEAD_BEEF);
    send_op(ACT_INS_AT, 6'd17, 32'h1);          // in range but full
    send_op(ACT_INS_AT, 6'd18, 32'h1);          // range wins over full
    send_op(ACT_INS_AT, 6'd0, 32'h1);
    send_op(ACT_REM_AT, 6'd17, 32'h0);
    send_op(ACT_REM_AT, 6'd16, 32'h0);          // last cell
    send_op(ACT_REM_AT, 6'd1, 32'h0);           // first cell, longest shift
    send_op(ACT_SPARE_6, 6'd5, 32'h0);
  endtask

  // Mostly well-formed edits with random content; add_pct steers the fill level.
  task automatic test_random_edits(input int n, input int add_pct);
    logic [ACTION_W-1:0]   act;
    logic [POSITION_W-1:0] pos;
    for (int i = 0; i < n; i++) begin
      pos = POSITION_W'($urandom);
      if ($urandom_range(0, 99) < 8) begin
        act = ACTION_W'($urandom_range(0, 7));   // noise: any code, any position
      end else if ($urandom_range(0, 99) < add_pct) begin
        case ($urandom_range(0, 2))
          0:       act = ACT_ADD_FRONT;
          1:       act = ACT_ADD_REAR;
          default: begin
            act = ACT_INS_AT;
            pos = POSITION_W'($urandom_range(1, seq_len + 1));
          end
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       act = ACT_REM_FRONT;
          1:       act = ACT_REM_REAR;
          default: begin
            act = ACT_REM_AT;
            pos = (seq_len == 0) ? 6'd1 : POSITION_W'($urandom_range(1, seq_len));
          end
        endcase
      end
      send_op(act, pos, $urandom);
    end
  endtask

  // Same traffic with no gaps on either side.
  task automatic test_back_to_back(input int n);
    calm = 1'b1;
    test_random_edits(n, 50);
    calm = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_store();
    test_fill_to_capacity();
    test_random_edits(400, 70);
    test_random_edits(400, 30);
    test_back_to_back(200);
    test_random_edits(300, 50);
    test_random_edits(250, 60);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/iss_pkg.sv
hdl/iss_ram.sv
hdl/indexed_sequence_store.sv
tb/tb_indexed_sequence_store.sv
